// ===== rtl/core/horspool_substring_search_macros.svh =====
// Assertion macros for the substring search block.
// Used by the top-level RTL file in this folder; no other dependencies.
`ifndef HORSPOOL_SUBSTRING_SEARCH_MACROS_SVH
`define HORSPOOL_SUBSTRING_SEARCH_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property, disabled while reset is high
`define HSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property that also holds during reset
`define HSS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define HSS_ASSERT(label, clk, rst, prop, msg)
`define HSS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/core/hss_pkg.sv =====
// Shared types and constants for the substring search block.
// No dependencies; imported by every module of the block.
package hss_pkg;

   // Default sizes
   localparam int HSS_TEXT_DEPTH  = 2048;
   localparam int HSS_MAX_PATTERN = 16;

   // Result position field width (fixed by the interface)
   localparam int HSS_POS_W = 11;

   // Register file
   localparam int HSS_CSR_IDX_W = 2;
   localparam logic [HSS_CSR_IDX_W-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [HSS_CSR_IDX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [HSS_CSR_IDX_W-1:0] CSR_PATTERN_LEN  = 2'd2;

   // Control sequencer
   typedef enum logic [1:0] {
      HSS_LOAD,
      HSS_SCAN,
      HSS_REPORT
   } hss_state_type;

   // Per-cycle control broadcast along the cell row
   typedef struct packed {
      logic       clear;   // drop all partial matches
      logic       shift;   // a text byte is presented this cycle
      logic [7:0] data;    // the text byte
   } hss_step_type;

endpackage

// ===== rtl/core/hss_text_buf.sv =====
// Text buffer: single write port, one registered read port.
// Depends on hss_pkg.
module hss_text_buf
   import hss_pkg::*;
#(
   parameter int DEPTH = HSS_TEXT_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data registered and valid the cycle after the address
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/hss_cell.sv =====
// One match cell: holds one pattern byte's partial-match flag and passes
// it to the next cell each time a text byte goes by. Depends on hss_pkg.
module hss_cell
   import hss_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  hss_step_type step,
   input  logic [7:0]   pat_byte,
   input  logic         prev_match,
   output logic         match_out,
   output logic         hit
);

   logic match_ff;
   logic match_in;

   // Pattern prefix up to this cell ends at the current byte
   assign hit = prev_match && (step.data == pat_byte);

   always_comb begin
      match_in = match_ff;
      if (step.clear) begin
         match_in = 1'b0;
      end else if (step.shift) begin
         match_in = hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign match_out = match_ff;

endmodule

// ===== rtl/core/horspool_substring_search.sv =====
// Substring search over a buffered text, top level.
// Depends on hss_pkg, hss_text_buf, hss_cell and the assertion macros.
//
// Usage:
//   Text bytes arrive on req_text_byte / req_last_byte; a request is taken
//   on a rising edge with start high and busy low, one byte per cycle while
//   the text loads. Bytes past TEXT_DEPTH are dropped and flagged.
//   The pattern (bytes 0..15) and its length are written through the
//   csr_ port (csr_ready is always high); the user must write them only
//   while the block is idle, which the block itself does not enforce.
//   After the request marked last, busy rises and the stored text is
//   replayed from the buffer, one byte per cycle, through a row of
//   MAX_PATTERN match cells. The scan stops at the first match; the one
//   read port of the buffer feeds the cell row.
//   The result stands for exactly one cycle; the receiver cannot stall.
//   Synchronous reset empties the text and restores the register resets;
//   the buffer needs no clearing pass.
`include "horspool_substring_search_macros.svh"

module horspool_substring_search
   import hss_pkg::*;
#(
   parameter int TEXT_DEPTH  = HSS_TEXT_DEPTH,
   parameter int MAX_PATTERN = HSS_MAX_PATTERN
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     start,
   output logic                     busy,
   input  logic [7:0]               req_text_byte,
   input  logic                     req_last_byte,
   // result channel
   output logic                     rsp_valid,
   output logic                     rsp_found,
   output logic [HSS_POS_W-1:0]     rsp_match_position,
   output logic                     rsp_overflow,
   // register writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [HSS_CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]              csr_data
);

   localparam int ADDR_W = $clog2(TEXT_DEPTH);
   localparam int CNT_W  = $clog2(TEXT_DEPTH + 1);
   localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W  = $clog2(MAX_PATTERN);
   localparam int PW     = (CNT_W > HSS_POS_W) ? CNT_W : HSS_POS_W;

   hss_state_type state_ff, state_in;

   logic [63:0]          pat_low_ff, pat_high_ff;
   logic [4:0]           pat_len_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic [CNT_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic                 rd_valid_ff;
   logic [ADDR_W-1:0]    rd_idx_ff;
   logic                 found_ff;
   logic [HSS_POS_W-1:0] pos_ff;

   logic                 accept, room, issue;
   logic                 hit_valid, scan_done, scan_exit;
   logic [7:0]           rd_data;
   logic [4:0]           eff_len;
   logic [LEN_W-1:0]     m_len, m_minus1;
   logic [PW-1:0]        pos_full;
   hss_step_type         step;
   logic [MAX_PATTERN-1:0] hit_vec, match_vec;

   // ---------------- register file ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= 5'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_data;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_data;
            CSR_PATTERN_LEN:  pat_len_ff  <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // Effective length, clamped to 1..MAX_PATTERN
   always_comb begin
      eff_len = pat_len_ff;
      if (pat_len_ff == 5'd0) begin
         eff_len = 5'd1;
      end else if (pat_len_ff > 5'(MAX_PATTERN)) begin
         eff_len = 5'(MAX_PATTERN);
      end
   end

   assign m_len    = eff_len[LEN_W-1:0];
   assign m_minus1 = m_len - LEN_W'(1);

   // ---------------- control ----------------
   assign accept    = start && !busy;
   assign room      = count_ff < CNT_W'(TEXT_DEPTH);
   assign issue     = (state_ff == HSS_SCAN) && (rd_ptr_ff < count_ff);
   assign hit_valid = rd_valid_ff && hit_vec[m_minus1[IDX_W-1:0]];
   assign scan_done = (rd_ptr_ff == count_ff) && !rd_valid_ff;
   assign scan_exit = (state_ff == HSS_SCAN) && (hit_valid || scan_done);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         HSS_LOAD: begin
            if (accept && req_last_byte) state_in = HSS_SCAN;
         end
         HSS_SCAN: begin
            if (hit_valid || scan_done) state_in = HSS_REPORT;
         end
         HSS_REPORT: state_in = HSS_LOAD;
         default:    state_in = HSS_LOAD;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         HSS_LOAD:   busy = 1'b0;
         HSS_SCAN:   busy = 1'b1;
         HSS_REPORT: rsp_valid = 1'b1;
         default:    busy = 1'b1;
      endcase
   end

   // Fill count and overflow
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (state_ff == HSS_REPORT) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (accept) begin
         if (room) count_in = count_ff + CNT_W'(1);
         else      ovf_in   = 1'b1;
      end
   end

   // Replay pointer
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      if (state_ff == HSS_LOAD) begin
         rd_ptr_in = '0;
      end else if (issue) begin
         rd_ptr_in = rd_ptr_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= HSS_LOAD;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         rd_ptr_ff   <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         rd_ptr_ff   <= rd_ptr_in;
         rd_valid_ff <= issue;
      end
   end

   // Offset of the byte now in the cell row
   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_ptr_ff[ADDR_W-1:0];
   end

   // Result capture: match start = end offset - (length - 1)
   assign pos_full = PW'(rd_idx_ff) - PW'(m_minus1);

   always_ff @(posedge clock) begin
      if (scan_exit) begin
         found_ff <= hit_valid;
         pos_ff   <= hit_valid ? pos_full[HSS_POS_W-1:0] : '0;
      end
   end

   assign rsp_found          = found_ff;
   assign rsp_match_position = pos_ff;
   assign rsp_overflow       = ovf_ff;

   // ---------------- text buffer ----------------
   hss_text_buf #(
      .DEPTH(TEXT_DEPTH)
   ) u_text_buf (
      .clock   (clock),
      .wr_en   (accept && room),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_text_byte),
      .rd_addr (rd_ptr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // ---------------- match cell row ----------------
   assign step.clear = (state_ff == HSS_LOAD);
   assign step.shift = rd_valid_ff;
   assign step.data  = rd_data;

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      logic [7:0] pat_byte;
      logic       prev_match;

      if (i < 8) begin : g_low
         assign pat_byte = pat_low_ff[8*i +: 8];
      end else begin : g_high
         assign pat_byte = pat_high_ff[8*(i-8) +: 8];
      end

      if (i == 0) begin : g_head
         assign prev_match = 1'b1;
      end else begin : g_link
         assign prev_match = match_vec[i-1];
      end

      hss_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .step       (step),
         .pat_byte   (pat_byte),
         .prev_match (prev_match),
         .match_out  (match_vec[i]),
         .hit        (hit_vec[i])
      );
   end

   // ---------------- assertions ----------------
   `HSS_ASSERT(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid, "result strobe held")
   `HSS_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(TEXT_DEPTH), "fill count overrun")
   `HSS_ASSERT(a_no_read_in_load, clock, reset,
               (state_ff == HSS_LOAD) |-> !rd_valid_ff, "stray buffer read")
   `HSS_ASSERT(a_pos_zero, clock, reset,
               (rsp_valid && !rsp_found) |-> (rsp_match_position == '0),
               "position set without match")
   `HSS_ASSERT(a_last_starts_scan, clock, reset,
               (accept && req_last_byte) |=> (state_ff == HSS_SCAN), "scan not started")

endmodule

// ===== tb/horspool_substring_search_tb.sv =====
// Self-checking testbench for horspool_substring_search: texts go in a byte per request,
// each search outcome is checked against an in-bench Horspool predictor.
// Depends on hss_pkg and the horspool_substring_search RTL.
`timescale 1ns / 100ps

module horspool_substring_search_tb
   import hss_pkg::*;
();

   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic                 found;
      logic [HSS_POS_W-1:0] position;
      logic                 overflow;
   } search_outcome_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [7:0]               req_text_byte = 8'h00;
   logic                     req_last_byte = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_found;
   logic [HSS_POS_W-1:0]     rsp_match_position;
   logic                     rsp_overflow;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [HSS_CSR_IDX_W-1:0] csr_index = CSR_PATTERN_LOW;
   logic [63:0]              csr_data = 64'h0;

   // predictor copy of the registers and of the text being loaded
   logic [63:0]        cfg_low = 64'h0;
   logic [63:0]        cfg_high = 64'h0;
   logic [4:0]         cfg_len = 5'd1;
   logic [7:0]         loaded_text[$];
   bit                 text_dropped = 1'b0;
   search_outcome_type pending_outcomes[$];
   search_outcome_type head_outcome;

   // stimulus scratch
   logic [7:0]  stim_text[$];
   logic [7:0]  stim_pattern[$];
   logic [7:0]  alphabet[3];
   bit          small_alphabet = 1'b0;
   int unsigned sender_idle_pct = 0;

   int unsigned error_count = 0;
   int unsigned items_sent = 0;
   int unsigned texts_sent = 0;
   int unsigned results_seen = 0;
   int unsigned found_seen = 0;
   int unsigned overflow_seen = 0;
   int unsigned csr_writes = 0;
   int unsigned quiet_cycles = 0;

   horspool_substring_search dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_text_byte      (req_text_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_found          (rsp_found),
      .rsp_match_position (rsp_match_position),
      .rsp_overflow       (rsp_overflow),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic [7:0] pattern_byte(input int unsigned i);
      if (i < 8)
         return cfg_low[8*i +: 8];
      return cfg_high[8*(i-8) +: 8];
   endfunction

   function automatic int unsigned effective_length();
      int unsigned m;
      m = 32'(cfg_len);
      if (m < 1)
         m = 1;
      if (m > HSS_MAX_PATTERN)
         m = HSS_MAX_PATTERN;
      return m;
   endfunction

   // Horspool skip loop over the loaded text, first match wins
   function automatic search_outcome_type predict_search();
      search_outcome_type r;
      logic [7:0]         pat[HSS_MAX_PATTERN];
      int unsigned        skip[256];
      int unsigned        m, n, p, i;
      logic [7:0]         c;
      bit                 hit;
      r.found = 1'b0;
      r.position = '0;
      r.overflow = text_dropped;
      m = effective_length();
      n = loaded_text.size();
      for (i = 0; i < m; i++)
         pat[i] = pattern_byte(i);
      for (i = 0; i < 256; i++)
         skip[i] = m;
      for (i = 0; i + 1 < m; i++)
         skip[pat[i]] = m - 1 - i;
      if (m <= n) begin
         p = 0;
         while (!r.found && p <= n - m) begin
            c = loaded_text[p + m - 1];
            hit = (c == pat[m - 1]);
            for (i = 0; hit && i + 1 < m; i++)
               if (loaded_text[p + i] != pat[i])
                  hit = 1'b0;
            if (hit) begin
               r.found = 1'b1;
               r.position = HSS_POS_W'(p);
            end else begin
               p += skip[c];
            end
         end
      end
      return r;
   endfunction

   // predictor side of one accepted request
   task automatic store_text_byte(input logic [7:0] value, input logic last);
      if (loaded_text.size() < HSS_TEXT_DEPTH)
         loaded_text.push_back(value);
      else
         text_dropped = 1'b1;
      if (last) begin
         pending_outcomes.push_back(predict_search());
         loaded_text.delete();
         text_dropped = 1'b0;
         texts_sent++;
      end
   endtask

   // one request; start stays high when the next one follows at once
   task automatic send_byte(input logic [7:0] value, input logic last);
      if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      start <= 1'b1;
      req_text_byte <= value;
      req_last_byte <= last;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      store_text_byte(value, last);
      items_sent++;
   endtask

   task automatic send_text();
      foreach (stim_text[i])
         send_byte(stim_text[i], i == stim_text.size() - 1);
   endtask

   // hold requests off until every outcome is in, then let the block settle
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high so writes can go back to back
   task automatic write_csr(input logic [HSS_CSR_IDX_W-1:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_PATTERN_LOW:  cfg_low = value;
         CSR_PATTERN_HIGH: cfg_high = value;
         CSR_PATTERN_LEN:  cfg_len = value[4:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // stim_pattern goes to the low bytes first; unused bytes get random filler
   task automatic program_pattern(input logic [63:0] length_word);
      logic [63:0] low_word;
      logic [63:0] high_word;
      wait_idle();
      low_word = {$urandom, $urandom};
      high_word = {$urandom, $urandom};
      foreach (stim_pattern[i]) begin
         if (i < 8)
            low_word[8*i +: 8] = stim_pattern[i];
         else
            high_word[8*(i-8) +: 8] = stim_pattern[i];
      end
      write_csr(CSR_PATTERN_LOW, low_word);
      write_csr(CSR_PATTERN_HIGH, high_word);
      write_csr(CSR_PATTERN_LEN, length_word);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == avoid)
         b = ~avoid;
      return b;
   endfunction

   // register defaults: a single 0x00 byte
   task automatic test_reset_defaults();
      stim_text = '{8'h00};
      send_text();
      stim_text = '{8'hFF};
      send_text();
      stim_text = '{8'hFF, 8'h00};
      send_text();
   endtask

   // length 0 acts as 1, 31 as 16, and a pattern longer than the text
   task automatic test_length_limits();
      stim_pattern = '{8'hFF};
      program_pattern(64'd0);
      stim_text = '{8'h00, 8'hFF};
      send_text();

      stim_pattern.delete();
      repeat (HSS_MAX_PATTERN) stim_pattern.push_back(8'($urandom_range(0, 255)));
      program_pattern(64'd31);
      stim_text = stim_pattern;
      send_text();

      program_pattern(64'd4);
      stim_text = '{stim_pattern[0], stim_pattern[1], stim_pattern[2]};
      send_text();
   endtask

   // the pattern is taken when the last byte arrives
   task automatic test_mid_text_update();
      stim_pattern = '{8'h78, 8'h79};
      program_pattern(64'd2);
      send_byte(8'h61, 1'b0);
      send_byte(8'h78, 1'b0);
      wait_idle();
      write_csr(CSR_PATTERN_LOW, {cfg_low[63:16], 8'h71, 8'h70});
      csr_valid <= 1'b0;
      send_byte(8'h70, 1'b0);
      send_byte(8'h71, 1'b1);
   endtask

   // full buffer with dropped bytes behind it; the match ends in the last slot
   task automatic test_buffer_overflow();
      stim_pattern = '{8'hA5, 8'h5A, 8'hC3};
      program_pattern(64'd3);
      stim_text.delete();
      repeat (HSS_TEXT_DEPTH + 12) stim_text.push_back(byte_other_than(8'hA5));
      foreach (stim_pattern[i]) begin
         stim_text[HSS_TEXT_DEPTH - 3 + i] = stim_pattern[i];
         stim_text[HSS_TEXT_DEPTH + 4 + i] = stim_pattern[i];
      end
      send_text();
   endtask

   task automatic random_pattern();
      logic [63:0] length_word;
      small_alphabet = ($urandom_range(0, 2) == 0);
      foreach (alphabet[i])
         alphabet[i] = 8'($urandom_range(0, 255));
      stim_pattern.delete();
      repeat (HSS_MAX_PATTERN)
         stim_pattern.push_back(small_alphabet ? alphabet[$urandom_range(0, 2)]
                                               : 8'($urandom_range(0, 255)));
      case ($urandom_range(0, 9))
         0:       length_word = $urandom_range(0, 1) ? 64'd0 : 64'($urandom_range(17, 31));
         1:       length_word = 64'd16;
         default: length_word = 64'($urandom_range(1, 16));
      endcase
      // upper bits of the length word are don't-care
      if ($urandom_range(0, 3) == 0)
         length_word[63:5] = 59'({$urandom, $urandom});
      program_pattern(length_word);
   endtask

   // mostly texts carrying the pattern, some corrupted, the rest noise
   task automatic random_text();
      int unsigned m, n, at, i;
      logic [7:0]  flip;
      m = effective_length();
      case ($urandom_range(0, 9))
         0:       n = $urandom_range(1, m);
         9:       n = $urandom_range(60, 120);
         default: n = $urandom_range(1, 40);
      endcase
      stim_text.delete();
      for (i = 0; i < n; i++)
         stim_text.push_back((small_alphabet && $urandom_range(0, 4) != 0)
                             ? alphabet[$urandom_range(0, 2)] : 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) < 6 && m <= n) begin
         at = $urandom_range(0, n - m);
         for (i = 0; i < m; i++)
            stim_text[at + i] = pattern_byte(i);
         if ($urandom_range(0, 3) == 0) begin
            i = at + $urandom_range(0, m - 1);
            flip = 8'(1 << $urandom_range(0, 7));
            stim_text[i] = stim_text[i] ^ flip;
         end
      end
      send_text();
   endtask

   task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned budget);
      int unsigned first_item;
      sender_idle_pct = idle_pct;
      first_item = items_sent;
      while (items_sent - first_item < budget) begin
         random_pattern();
         repeat ($urandom_range(3, 10)) random_text();
         // let everything drain now and then while the pattern stays
         if ($urandom_range(0, 3) == 0) begin
            wait_idle();
            repeat ($urandom_range(1, 4)) random_text();
         end
      end
      wait_idle();
      sender_idle_pct = 0;
   endtask

   // compare each outcome with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("search outcome with no text pending");
         end else begin
            head_outcome = pending_outcomes.pop_front();
            if (rsp_found !== head_outcome.found)
               report_mismatch($sformatf("found %b, predicted %b",
                                         rsp_found, head_outcome.found));
            if (rsp_match_position !== head_outcome.position)
               report_mismatch($sformatf("match_position %0d, predicted %0d",
                                         rsp_match_position, head_outcome.position));
            if (rsp_overflow !== head_outcome.overflow)
               report_mismatch($sformatf("overflow %b, predicted %b",
                                         rsp_overflow, head_outcome.overflow));
            results_seen++;
            if (head_outcome.found)
               found_seen++;
            if (head_outcome.overflow)
               overflow_seen++;
         end
      end
   end

   // watchdog: no request, outcome or register write for too long
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1 || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", quiet_cycles);
            $display("horspool_substring_search_tb: done, errors");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_length_limits();
      test_mid_text_update();
      test_buffer_overflow();
      test_random_traffic(0, 200);
      test_random_traffic(72, 150);
      test_random_traffic(16, 200);

      wait_idle();
      if (pending_outcomes.size() != 0)
         report_mismatch($sformatf("%0d outcomes never arrived", pending_outcomes.size()));
      $display("covered %0d text bytes in %0d texts, %0d pattern register writes",
               items_sent, texts_sent, csr_writes);
      $display("checked %0d outcomes: %0d with a match, %0d with buffer overflow",
               results_seen, found_seen, overflow_seen);
      if (error_count == 0)
         $display("horspool_substring_search_tb: done, clean");
      else
         $display("horspool_substring_search_tb: done, errors");
      $finish;
   end

endmodule
